// ===== rtl/core/ufe_pkg.sv =====
// Shared types and constants of the enemy-aware disjoint-set store.
`timescale 1ns / 1ps

package ufe_pkg;

   typedef enum logic [1:0] {
      KIND_AGREE    = 2'd0,
      KIND_DISAGREE = 2'd1,
      KIND_REPORT   = 2'd2,
      KIND_CLEAR    = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [9:0] first_node;
      logic [9:0] second_node;
   } req_type;

   typedef struct packed {
      logic        contradiction;
      logic [15:0] contradiction_at;
      logic [10:0] max_party_size;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_RPT_RD,
      ST_RPT_CHK,
      ST_RPT_OPP,
      ST_FIND_RD,
      ST_FIND_WALK,
      ST_CMP_RD,
      ST_CMP_WR,
      ST_FDONE,
      ST_U1,
      ST_U2,
      ST_LINK_L,
      ST_LINK_W,
      ST_UDONE,
      ST_ENM_RD,
      ST_ENM_WR,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      CALL_FA,
      CALL_FB,
      CALL_UP,
      CALL_UQ
   } call_type;

   localparam logic [10:0] NODE_COUNT_RESET = 11'd1024;
   localparam logic [15:0] STMT_MAX         = 16'hFFFF;
   localparam logic [10:0] PARTY_MAX        = 11'd2047;

endpackage

// ===== rtl/core/union_find_with_enemies_top.sv =====
// Top level: enemy-aware disjoint-set store with one shared entry memory.
//
//   channel | dir | handshake              | payload
//   req     | in  | req_valid / req_ready  | req_data  (ufe_pkg::req_type)
//   rsp     | out | rsp_valid / rsp_ready  | rsp_data  (ufe_pkg::rsp_type)
//   csr     | in  | csr_write_en           | csr_write_data (node count)
//
// One transaction at a time; every memory access goes through the single port.
// Statement: two root finds with path compression, then unions and enemy-link writes, unless dropped.
// Report: reads every node in use, and the opponent entry of each root that counts its opponent.
// Clear: rewrites all MAX_NODES entries.
// After reset a clearing pass over all MAX_NODES entries runs with req_ready low.
// A finished transaction waits in the output register; the next one is taken meanwhile.
`timescale 1ns / 1ps

module union_find_with_enemies_top #(
   parameter int MAX_NODES = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ufe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ufe_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [10:0]      csr_write_data
);

   localparam int AW = $clog2(MAX_NODES);
   localparam int SW = $clog2(MAX_NODES + 1);
   localparam int RW = $clog2(AW + 1);
   localparam int PW = ((SW > 11) ? SW : 11) + 1;

   typedef struct packed {
      logic [AW-1:0] parent;
      logic [RW-1:0] rank;
      logic [SW-1:0] size;
      logic          ev;
      logic [AW-1:0] er;
   } ent_type;

   ent_type mem [0:MAX_NODES-1];
   ent_type mem_rd;
   ent_type mem_wd;
   logic [AW-1:0] mem_addr;
   logic mem_we, mem_re;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wd;
      end
      if (mem_re) begin
         mem_rd <= mem[mem_addr];
      end
   end

   ufe_pkg::state_type state_ff, state_in;
   ufe_pkg::call_type  call_ff, call_in;
   logic uphase_ff, uphase_in, estep_ff, estep_in, agree_ff, agree_in;
   logic [10:0] node_count_ff, node_count_in;
   logic [15:0] stmt_ff, stmt_in, fc_ff, fc_in;
   logic [10:0] party_ff, party_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [AW-1:0] b_ff, b_in;
   logic [AW-1:0] fnode_ff, fnode_in, fcur_ff, fcur_in, fcomp_ff, fcomp_in;
   logic [AW-1:0] froot_ff, froot_in;
   ent_type froot_ent_ff, froot_ent_in;
   logic [AW-1:0] ra_ff, ra_in, rb_ff, rb_in, ea_ff, ea_in, eb_ff, eb_in;
   logic va_ff, va_in, vb_ff, vb_in;
   logic [AW-1:0] uq_ff, uq_in, pr_ff, pr_in;
   ent_type pent_ff, pent_in;
   logic [AW-1:0] lose_ff, lose_in, win_ff, win_in, ures_ff, ures_in;
   ent_type lent_ff, lent_in, went_ff, went_in;
   logic [AW-1:0] x_ff, x_in, y_ff, y_in;
   logic vy_ff, vy_in;
   logic [SW-1:0] cur_ff, cur_in;
   logic rsp_valid_ff, rsp_valid_in;
   ufe_pkg::rsp_type rsp_ff, rsp_in;

   logic [SW-1:0] eff;
   logic [AW-1:0] idx_a;
   logic in_range, conflict_now, swap;
   ent_type reset_ent, cmp_ent, enm_ent, lnk_win;
   logic [SW-1:0] pick;
   logic [PW-1:0] party_sum;

   assign idx_a = idx_ff[AW-1:0];
   assign eff = (32'(node_count_ff) > MAX_NODES) ? SW'(MAX_NODES) : SW'(node_count_ff);
   assign in_range = (32'(req_data.first_node) < 32'(eff))
                  && (32'(req_data.second_node) < 32'(eff));
   assign conflict_now = agree_ff ? (va_ff && (ea_ff == froot_ff)) : (ra_ff == froot_ff);

   always_comb begin
      reset_ent        = '0;
      reset_ent.parent = idx_a;
      reset_ent.size   = SW'(1);
      cmp_ent          = mem_rd;
      cmp_ent.parent   = froot_ff;
      enm_ent          = mem_rd;
      enm_ent.ev       = estep_ff ? 1'b1 : vy_ff;
      enm_ent.er       = estep_ff ? x_ff : (vy_ff ? y_ff : '0);
   end

   assign swap = pent_ff.rank > froot_ent_ff.rank;
   always_comb begin
      lnk_win      = swap ? pent_ff : froot_ent_ff;
      lnk_win.rank = lnk_win.rank + RW'(pent_ff.rank == froot_ent_ff.rank);
      lnk_win.size = lnk_win.size + (swap ? froot_ent_ff.size : pent_ff.size);
   end

   assign pick      = (cur_ff > mem_rd.size) ? cur_ff : mem_rd.size;
   assign party_sum = PW'(party_ff) + PW'(state_ff == ufe_pkg::ST_RPT_OPP ? pick : mem_rd.size);

   assign node_count_in = csr_write_en ? csr_write_data : node_count_ff;

   always_comb begin
      state_in = state_ff;   call_in = call_ff;     uphase_in = uphase_ff;
      estep_in = estep_ff;   agree_in = agree_ff;   stmt_in = stmt_ff;
      fc_in = fc_ff;         party_in = party_ff;   idx_in = idx_ff;
      b_in = b_ff;           fnode_in = fnode_ff;
      fcur_in = fcur_ff;     fcomp_in = fcomp_ff;   froot_in = froot_ff;
      froot_ent_in = froot_ent_ff;
      ra_in = ra_ff;         rb_in = rb_ff;         ea_in = ea_ff;
      eb_in = eb_ff;         va_in = va_ff;         vb_in = vb_ff;
      uq_in = uq_ff;         pr_in = pr_ff;         pent_in = pent_ff;
      lose_in = lose_ff;     win_in = win_ff;       ures_in = ures_ff;
      lent_in = lent_ff;     went_in = went_ff;
      x_in = x_ff;           y_in = y_ff;           vy_in = vy_ff;
      cur_in = cur_ff;       rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we = 1'b0;  mem_re = 1'b0;  mem_addr = fnode_ff;  mem_wd = mem_rd;

      case (state_ff)
         ufe_pkg::ST_INIT, ufe_pkg::ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = idx_a;
            mem_wd   = reset_ent;
            idx_in   = idx_ff + SW'(1);
            if (idx_a == AW'(MAX_NODES - 1)) begin
               idx_in   = '0;
               state_in = (state_ff == ufe_pkg::ST_INIT) ? ufe_pkg::ST_IDLE
                                                         : ufe_pkg::ST_FINISH;
            end
         end
         ufe_pkg::ST_IDLE: begin
            if (req_valid) begin
               party_in = '0;
               idx_in   = '0;
               b_in     = AW'(req_data.second_node);
               agree_in = (req_data.kind == ufe_pkg::KIND_AGREE);
               case (req_data.kind)
                  ufe_pkg::KIND_CLEAR: begin
                     stmt_in  = '0;
                     fc_in    = '0;
                     state_in = ufe_pkg::ST_CLEAR;
                  end
                  ufe_pkg::KIND_REPORT: begin
                     state_in = (fc_ff != '0) ? ufe_pkg::ST_FINISH : ufe_pkg::ST_RPT_RD;
                  end
                  default: begin
                     if (fc_ff == '0 && in_range) begin
                        if (stmt_ff != ufe_pkg::STMT_MAX) begin
                           stmt_in = stmt_ff + 16'd1;
                        end
                        fnode_in = AW'(req_data.first_node);
                        call_in  = ufe_pkg::CALL_FA;
                        state_in = ufe_pkg::ST_FIND_RD;
                     end else begin
                        state_in = ufe_pkg::ST_FINISH;
                     end
                  end
               endcase
            end
         end
         ufe_pkg::ST_RPT_RD: begin
            if (idx_ff == eff) begin
               state_in = ufe_pkg::ST_FINISH;
            end else begin
               mem_re   = 1'b1;
               mem_addr = idx_a;
               state_in = ufe_pkg::ST_RPT_CHK;
            end
         end
         ufe_pkg::ST_RPT_CHK: begin
            state_in = ufe_pkg::ST_RPT_RD;
            idx_in   = idx_ff + SW'(1);
            if (mem_rd.parent == idx_a && !(mem_rd.ev && idx_a < mem_rd.er)) begin
               if (mem_rd.ev) begin
                  cur_in   = mem_rd.size;
                  mem_re   = 1'b1;
                  mem_addr = mem_rd.er;
                  idx_in   = idx_ff;
                  state_in = ufe_pkg::ST_RPT_OPP;
               end else begin
                  party_in = (party_sum > PW'(ufe_pkg::PARTY_MAX)) ? ufe_pkg::PARTY_MAX
                                                                   : 11'(party_sum);
               end
            end
         end
         ufe_pkg::ST_RPT_OPP: begin
            party_in = (party_sum > PW'(ufe_pkg::PARTY_MAX)) ? ufe_pkg::PARTY_MAX
                                                             : 11'(party_sum);
            idx_in   = idx_ff + SW'(1);
            state_in = ufe_pkg::ST_RPT_RD;
         end
         ufe_pkg::ST_FIND_RD: begin
            mem_re   = 1'b1;
            mem_addr = fnode_ff;
            fcur_in  = fnode_ff;
            state_in = ufe_pkg::ST_FIND_WALK;
         end
         ufe_pkg::ST_FIND_WALK: begin
            if (mem_rd.parent == fcur_ff) begin
               froot_in     = fcur_ff;
               froot_ent_in = mem_rd;
               fcomp_in     = fnode_ff;
               state_in     = (fnode_ff == fcur_ff) ? ufe_pkg::ST_FDONE : ufe_pkg::ST_CMP_RD;
            end else begin
               fcur_in  = mem_rd.parent;
               mem_re   = 1'b1;
               mem_addr = mem_rd.parent;
            end
         end
         ufe_pkg::ST_CMP_RD: begin
            mem_re   = 1'b1;
            mem_addr = fcomp_ff;
            state_in = ufe_pkg::ST_CMP_WR;
         end
         ufe_pkg::ST_CMP_WR: begin
            mem_we   = 1'b1;
            mem_addr = fcomp_ff;
            mem_wd   = cmp_ent;
            fcomp_in = mem_rd.parent;
            state_in = (mem_rd.parent == froot_ff) ? ufe_pkg::ST_FDONE : ufe_pkg::ST_CMP_RD;
         end
         ufe_pkg::ST_FDONE: begin
            case (call_ff)
               ufe_pkg::CALL_FA: begin
                  ra_in    = froot_ff;
                  va_in    = froot_ent_ff.ev;
                  ea_in    = froot_ent_ff.er;
                  fnode_in = b_ff;
                  call_in  = ufe_pkg::CALL_FB;
                  state_in = ufe_pkg::ST_FIND_RD;
               end
               ufe_pkg::CALL_FB: begin
                  rb_in = froot_ff;
                  vb_in = froot_ent_ff.ev;
                  eb_in = froot_ent_ff.er;
                  if (conflict_now) begin
                     fc_in = stmt_ff;
                  end
                  state_in = ufe_pkg::ST_U1;
               end
               ufe_pkg::CALL_UP: begin
                  pr_in    = froot_ff;
                  pent_in  = froot_ent_ff;
                  fnode_in = uq_ff;
                  call_in  = ufe_pkg::CALL_UQ;
                  state_in = ufe_pkg::ST_FIND_RD;
               end
               default: begin
                  if (pr_ff == froot_ff) begin
                     ures_in  = pr_ff;
                     state_in = ufe_pkg::ST_UDONE;
                  end else begin
                     lose_in  = swap ? froot_ff : pr_ff;
                     win_in   = swap ? pr_ff : froot_ff;
                     lent_in  = swap ? froot_ent_ff : pent_ff;
                     went_in  = lnk_win;
                     state_in = ufe_pkg::ST_LINK_L;
                  end
               end
            endcase
         end
         ufe_pkg::ST_U1: begin
            uphase_in = 1'b0;
            call_in   = ufe_pkg::CALL_UP;
            fnode_in  = ra_ff;
            uq_in     = agree_ff ? rb_ff : eb_ff;
            if (agree_ff || vb_ff) begin
               state_in = ufe_pkg::ST_FIND_RD;
            end else begin
               x_in     = ra_ff;
               state_in = ufe_pkg::ST_U2;
            end
         end
         ufe_pkg::ST_U2: begin
            uphase_in = 1'b1;
            call_in   = ufe_pkg::CALL_UP;
            estep_in  = 1'b0;
            vy_in     = agree_ff ? (va_ff || vb_ff) : 1'b1;
            fnode_in  = agree_ff ? ea_ff : rb_ff;
            uq_in     = agree_ff ? eb_ff : ea_ff;
            if (agree_ff ? (va_ff && vb_ff) : va_ff) begin
               state_in = ufe_pkg::ST_FIND_RD;
            end else begin
               y_in     = agree_ff ? (va_ff ? ea_ff : eb_ff) : rb_ff;
               state_in = ufe_pkg::ST_ENM_RD;
            end
         end
         ufe_pkg::ST_LINK_L: begin
            mem_we        = 1'b1;
            mem_addr      = lose_ff;
            mem_wd        = lent_ff;
            mem_wd.parent = win_ff;
            state_in      = ufe_pkg::ST_LINK_W;
         end
         ufe_pkg::ST_LINK_W: begin
            mem_we   = 1'b1;
            mem_addr = win_ff;
            mem_wd   = went_ff;
            ures_in  = win_ff;
            state_in = ufe_pkg::ST_UDONE;
         end
         ufe_pkg::ST_UDONE: begin
            estep_in = 1'b0;
            if (uphase_ff) begin
               y_in     = ures_ff;
               state_in = ufe_pkg::ST_ENM_RD;
            end else begin
               x_in     = ures_ff;
               state_in = ufe_pkg::ST_U2;
            end
         end
         ufe_pkg::ST_ENM_RD: begin
            mem_re   = 1'b1;
            mem_addr = estep_ff ? y_ff : x_ff;
            state_in = ufe_pkg::ST_ENM_WR;
         end
         ufe_pkg::ST_ENM_WR: begin
            mem_we   = 1'b1;
            mem_addr = estep_ff ? y_ff : x_ff;
            mem_wd   = enm_ent;
            if (!estep_ff && vy_ff) begin
               estep_in = 1'b1;
               state_in = ufe_pkg::ST_ENM_RD;
            end else begin
               state_in = ufe_pkg::ST_FINISH;
            end
         end
         ufe_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                = 1'b1;
               rsp_in.contradiction        = (fc_ff != '0);
               rsp_in.contradiction_at     = fc_ff;
               rsp_in.max_party_size       = party_ff;
               state_in                    = ufe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ufe_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ufe_pkg::ST_INIT;
         idx_ff        <= '0;
         node_count_ff <= ufe_pkg::NODE_COUNT_RESET;
         stmt_ff       <= '0;
         fc_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         node_count_ff <= node_count_in;
         stmt_ff       <= stmt_in;
         fc_ff         <= fc_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      call_ff <= call_in;     uphase_ff <= uphase_in;   estep_ff <= estep_in;
      agree_ff <= agree_in;   party_ff <= party_in;
      b_ff <= b_in;           fnode_ff <= fnode_in;
      fcur_ff <= fcur_in;     fcomp_ff <= fcomp_in;     froot_ff <= froot_in;
      froot_ent_ff <= froot_ent_in;
      ra_ff <= ra_in;         rb_ff <= rb_in;           ea_ff <= ea_in;
      eb_ff <= eb_in;         va_ff <= va_in;           vb_ff <= vb_in;
      uq_ff <= uq_in;         pr_ff <= pr_in;           pent_ff <= pent_in;
      lose_ff <= lose_in;     win_ff <= win_in;         ures_ff <= ures_in;
      lent_ff <= lent_in;     went_ff <= went_in;
      x_ff <= x_in;           y_ff <= y_in;             vy_ff <= vy_in;
      cur_ff <= cur_in;       rsp_ff <= rsp_in;
   end

   assign req_ready = (state_ff == ufe_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/ufe_checker.sv =====
// Port checker for the enemy-aware disjoint-set store, with its bind.
`timescale 1ns / 1ps

module ufe_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ufe_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before acceptance");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

   a_flag_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.contradiction == (rsp_data.contradiction_at != 16'd0)))
      else $error("contradiction flag disagrees with its statement number");

   a_no_party: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.contradiction |-> (rsp_data.max_party_size == 11'd0))
      else $error("party size reported after a contradiction");

endmodule

bind union_find_with_enemies_top ufe_checker u_ufe_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/union_find_with_enemies_top_test.sv =====
// Self-checking testbench for the enemy-aware disjoint-set store: directed table then random phases.
`timescale 1ns / 1ps

module union_find_with_enemies_top_test;

   localparam int NODES = 1024;
   localparam int STALL_LIMIT = 60000;
   localparam int HOLD_CYCLES = 700;

   typedef struct {
      ufe_pkg::kind_type kind;
      int       a;
      int       b;
      bit       typed;
      bit       con;
      int       at;
      int       party;
   } dir_row_type;

   typedef struct {
      int count;
      int items;
   } phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   ufe_pkg::req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   ufe_pkg::rsp_type rsp_data;
   logic        csr_write_en = 1'b0;
   logic [10:0] csr_write_data = '0;

   int parent [NODES];
   int rank_of [NODES];
   int set_sz [NODES];
   bit enemy_ok [NODES];
   int enemy_of [NODES];
   int stmt_count;
   int first_conflict;
   int node_count;

   ufe_pkg::rsp_type pending_rsp [$];
   int  errors = 0;
   int  snd_idle = 0;
   int  rcv_idle = 0;
   bit  holdoff_req = 0;
   int  n_stmt = 0, n_report = 0, n_clear = 0, n_conflict = 0;

   dir_row_type dir_rows [0:17] = '{
      '{ufe_pkg::KIND_REPORT,   0,    0,    1, 0, 0, 1024},
      '{ufe_pkg::KIND_AGREE,    0,    1023, 0, 0, 0, 0},
      '{ufe_pkg::KIND_DISAGREE, 0,    1,    0, 0, 0, 0},
      '{ufe_pkg::KIND_AGREE,    1022, 1021, 0, 0, 0, 0},
      '{ufe_pkg::KIND_DISAGREE, 1023, 1022, 0, 0, 0, 0},
      '{ufe_pkg::KIND_REPORT,   0,    0,    0, 0, 0, 0},
      '{ufe_pkg::KIND_AGREE,    1,    1022, 0, 0, 0, 0},
      '{ufe_pkg::KIND_DISAGREE, 1,    1,    1, 1, 6, 0},
      '{ufe_pkg::KIND_AGREE,    5,    6,    1, 1, 6, 0},
      '{ufe_pkg::KIND_REPORT,   0,    0,    1, 1, 6, 0},
      '{ufe_pkg::KIND_CLEAR,    0,    0,    1, 0, 0, 0},
      '{ufe_pkg::KIND_AGREE,    3,    4,    0, 0, 0, 0},
      '{ufe_pkg::KIND_DISAGREE, 4,    3,    1, 1, 2, 0},
      '{ufe_pkg::KIND_CLEAR,    1023, 1023, 1, 0, 0, 0},
      '{ufe_pkg::KIND_DISAGREE, 7,    8,    0, 0, 0, 0},
      '{ufe_pkg::KIND_AGREE,    8,    7,    1, 1, 2, 0},
      '{ufe_pkg::KIND_CLEAR,    0,    0,    1, 0, 0, 0},
      '{ufe_pkg::KIND_REPORT,   0,    0,    1, 0, 0, 1024}
   };

   phase_type phases [0:8] = '{
      '{16, 320}, '{0, 20}, '{1, 30}, '{64, 300}, '{2047, 110},
      '{8, 320}, '{256, 240}, '{1024, 120}, '{32, 200}
   };

   union_find_with_enemies_top uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic void clear_sets();
      for (int i = 0; i < NODES; i++) begin
         parent[i] = i;
         rank_of[i] = 0;
         set_sz[i] = 1;
         enemy_ok[i] = 0;
         enemy_of[i] = 0;
      end
      stmt_count = 0;
      first_conflict = 0;
   endfunction

   function automatic int root_of(int x);
      int r, c, nx;
      r = x % NODES;
      while (parent[r] != r) r = parent[r];
      c = x % NODES;
      while (c != r) begin
         nx = parent[c];
         parent[c] = r;
         c = nx;
      end
      return r;
   endfunction

   function automatic int merge_sets(int a, int b);
      int t;
      a = root_of(a);
      b = root_of(b);
      if (a == b) return a;
      if (rank_of[a] > rank_of[b]) begin
         t = a; a = b; b = t;
      end
      if (rank_of[a] == rank_of[b] && rank_of[b] < 255) rank_of[b]++;
      parent[a] = b;
      set_sz[b] += set_sz[a];
      return b;
   endfunction

   function automatic int party_sum(int eff);
      int sum, cur, opp;
      sum = 0;
      for (int i = 0; i < eff; i++) begin
         if (parent[i] != i) continue;
         if (enemy_ok[i] && i < enemy_of[i]) continue;
         cur = set_sz[i];
         opp = enemy_ok[i] ? set_sz[enemy_of[i] % NODES] : 0;
         sum += (cur > opp) ? cur : opp;
         if (sum > 2047) sum = 2047;
      end
      return sum;
   endfunction

   function automatic ufe_pkg::rsp_type apply_item(ufe_pkg::req_type d);
      int eff, a, b, x, y, ea, eb, party;
      bit va, vb, vy, conflict;
      ufe_pkg::rsp_type r;
      eff = (node_count > NODES) ? NODES : node_count;
      a = int'(d.first_node);
      b = int'(d.second_node);
      party = 0;
      conflict = 0;
      if (d.kind == ufe_pkg::KIND_CLEAR) begin
         clear_sets();
         n_clear++;
      end else if (d.kind == ufe_pkg::KIND_REPORT) begin
         n_report++;
         if (first_conflict == 0) party = party_sum(eff);
      end else if (first_conflict == 0 && a < eff && b < eff) begin
         n_stmt++;
         if (stmt_count < 65535) stmt_count++;
         a = root_of(a);
         b = root_of(b);
         if (d.kind == ufe_pkg::KIND_AGREE) begin
            va = enemy_ok[a];
            vb = enemy_ok[b];
            ea = enemy_of[a];
            eb = enemy_of[b];
            if (va && ea == b) conflict = 1;
            x = merge_sets(a, b);
            vy = va || vb;
            if (!va) y = eb;
            else if (!vb) y = ea;
            else y = merge_sets(ea, eb);
            y = y % NODES;
            enemy_ok[x] = vy;
            enemy_of[x] = vy ? y : 0;
            if (vy) begin
               enemy_ok[y] = 1;
               enemy_of[y] = x;
            end
         end else begin
            if (a == b) conflict = 1;
            x = enemy_ok[b] ? merge_sets(a, enemy_of[b]) : a;
            y = enemy_ok[a] ? merge_sets(b, enemy_of[a]) : b;
            x = x % NODES;
            y = y % NODES;
            enemy_ok[x] = 1;
            enemy_of[x] = y;
            enemy_ok[y] = 1;
            enemy_of[y] = x;
         end
         if (conflict) begin
            first_conflict = stmt_count;
            n_conflict++;
         end
      end
      r.contradiction = (first_conflict != 0);
      r.contradiction_at = first_conflict[15:0];
      r.max_party_size = party[10:0];
      return r;
   endfunction

   // offer one transaction; returns at a falling edge after acceptance
   task automatic offer(ufe_pkg::req_type d, bit typed, ufe_pkg::rsp_type typed_rsp);
      ufe_pkg::rsp_type predicted;
      bit taken;
      if ($urandom_range(99) < snd_idle) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      taken = 0;
      while (!taken) begin
         @(posedge clock);
         taken = req_ready;
      end
      predicted = apply_item(d);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_count(int value);
      csr_write_en <= 1'b1;
      csr_write_data <= value[10:0];
      @(negedge clock);
      csr_write_en <= 1'b0;
      node_count = value & 'h7FF;
   endtask

   function automatic ufe_pkg::req_type random_item(int eff);
      ufe_pkg::req_type d;
      int roll, span;
      roll = $urandom_range(99);
      span = (eff > 0) ? eff - 1 : 0;
      d.first_node = 10'($urandom_range(span));
      d.second_node = 10'($urandom_range(span));
      d.kind = ($urandom_range(1)) ? ufe_pkg::KIND_AGREE : ufe_pkg::KIND_DISAGREE;
      if (first_conflict != 0 && roll < 35) d.kind = ufe_pkg::KIND_CLEAR;
      else if (roll < 6 || eff == 0) begin
         d.first_node = 10'($urandom);
         d.second_node = 10'($urandom);
         d.kind = ufe_pkg::kind_type'($urandom_range(3));
      end else if (roll < 6 + ((eff > 300) ? 1 : 6)) d.kind = ufe_pkg::KIND_REPORT;
      else if (roll == 99) d.kind = ufe_pkg::KIND_CLEAR;
      return d;
   endfunction

   initial begin
      forever begin
         @(negedge clock);
         if (holdoff_req) begin
            holdoff_req = 0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= rcv_idle);
      end
   end

   always @(posedge clock) begin
      ufe_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected transaction on rsp: %p", rsp_data);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.contradiction !== want.contradiction) begin
               $error("contradiction: expected %0d, got %0d",
                      want.contradiction, rsp_data.contradiction);
               errors++;
            end
            if (rsp_data.contradiction_at !== want.contradiction_at) begin
               $error("contradiction_at: expected %0d, got %0d",
                      want.contradiction_at, rsp_data.contradiction_at);
               errors++;
            end
            if (rsp_data.max_party_size !== want.max_party_size) begin
               $error("max_party_size: expected %0d, got %0d",
                      want.max_party_size, rsp_data.max_party_size);
               errors++;
            end
         end
      end
   end

   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      ufe_pkg::req_type d;
      ufe_pkg::rsp_type t;
      int total, done_items, eff;
      node_count = 1024;
      clear_sets();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      snd_idle = 24;
      rcv_idle = 56;
      foreach (dir_rows[i]) begin
         d.kind = dir_rows[i].kind;
         d.first_node = 10'(dir_rows[i].a);
         d.second_node = 10'(dir_rows[i].b);
         t.contradiction = dir_rows[i].con;
         t.contradiction_at = 16'(dir_rows[i].at);
         t.max_party_size = 11'(dir_rows[i].party);
         offer(d, dir_rows[i].typed, t);
      end
      drain();

      total = 0;
      foreach (phases[p]) total += phases[p].items;
      done_items = 0;
      foreach (phases[p]) begin
         write_count(phases[p].count);
         eff = (node_count > NODES) ? NODES : node_count;
         for (int k = 0; k < phases[p].items; k++) begin
            if (done_items < total / 3) begin
               snd_idle = 24; rcv_idle = 56;
            end else if (done_items < 2 * total / 3) begin
               snd_idle = 56; rcv_idle = 24;
            end else begin
               snd_idle = 0; rcv_idle = 0;
            end
            if (p == 3 && k == 40) holdoff_req = 1;
            if (p == 5 && k == 100) drain();
            offer(random_item(eff), 0, t);
            done_items++;
         end
         drain();
      end

      repeat (50) @(posedge clock);
      $display("covered %0d statements, %0d reports, %0d clears, %0d conflicts",
               n_stmt, n_report, n_clear, n_conflict);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
